### design/tensor_symmetry_address_generator_unit_defines.svh
// Assertion macros for the address generator RTL.
`ifndef TENSOR_SYMMETRY_ADDRESS_GENERATOR_UNIT_DEFINES_SVH
`define TENSOR_SYMMETRY_ADDRESS_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSAG_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSAG_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tsag_pkg.sv
// Shared types and constants of the tensor symmetry address generator.
package tsag_pkg;

	localparam int IDX_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int BATCH_REG_W = 9;
	localparam int SIDE_REG_W  = 6;
	localparam int CHAN_REG_W  = 7;
	localparam int SYM_W       = 3;

	// symmetry code bits
	localparam logic [SYM_W-1:0] SYM_TRANSPOSE = 3'h4;
	localparam logic [SYM_W-1:0] SYM_FLIP_X    = 3'h2;
	localparam logic [SYM_W-1:0] SYM_FLIP_Y    = 3'h1;

	// channel pair swapped under a single flip when the channel count is SWAP_PLANE_COUNT
	localparam int CHAN_SWAP_A = 6;
	localparam int CHAN_SWAP_B = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATCH_COUNT   = 3'd0,
		REG_HEIGHT        = 3'd1,
		REG_WIDTH         = 3'd2,
		REG_CHANNEL_COUNT = 3'd3,
		REG_LAYOUT_NHWC   = 3'd4,
		REG_SYMMETRY_CODE = 3'd5,
		REG_REVERSE_COPY  = 3'd6
	} cfg_reg_t;

	// multiply-add pass, outermost dimension first
	typedef enum logic [1:0] {
		STEP_OUTER = 2'd0,
		STEP_MID   = 2'd1,
		STEP_INNER = 2'd2
	} mac_step_t;

	typedef struct packed {
		logic      load;
		logic      mac_en;
		mac_step_t step;
		logic      push;
	} tsag_cmd_t;

	typedef struct packed {
		logic out_free;
	} tsag_status_t;

endpackage

### design/tsag_cfg_regs.sv
// Configuration registers and clamped effective counts.
module tsag_cfg_regs #(
	parameter int MAX_SIDE     = 32,
	parameter int MAX_BATCH    = 256,
	parameter int MAX_CHANNELS = 64,
	localparam int NBW = $clog2(MAX_BATCH + 1),
	localparam int NSW = $clog2(MAX_SIDE + 1),
	localparam int NCW = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [NBW-1:0]                      nb,
	output logic [NSW-1:0]                      nh,
	output logic [NSW-1:0]                      nw,
	output logic [NCW-1:0]                      nc,
	output logic                                layout_nhwc,
	output logic [tsag_pkg::SYM_W-1:0]          symmetry_code,
	output logic                                reverse_copy
);
	import tsag_pkg::*;

	logic [BATCH_REG_W-1:0] batch_count_q;
	logic [SIDE_REG_W-1:0]  height_q;
	logic [SIDE_REG_W-1:0]  width_q;
	logic [CHAN_REG_W-1:0]  channel_count_q;
	logic                   layout_nhwc_q;
	logic [SYM_W-1:0]       symmetry_code_q;
	logic                   reverse_copy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_count_q   <= BATCH_REG_W'(1);
			height_q        <= SIDE_REG_W'(1);
			width_q         <= SIDE_REG_W'(1);
			channel_count_q <= CHAN_REG_W'(1);
			layout_nhwc_q   <= 1'b0;
			symmetry_code_q <= '0;
			reverse_copy_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BATCH_COUNT:   batch_count_q   <= cfg_data[BATCH_REG_W-1:0];
				REG_HEIGHT:        height_q        <= cfg_data[SIDE_REG_W-1:0];
				REG_WIDTH:         width_q         <= cfg_data[SIDE_REG_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHAN_REG_W-1:0];
				REG_LAYOUT_NHWC:   layout_nhwc_q   <= cfg_data[0];
				REG_SYMMETRY_CODE: symmetry_code_q <= cfg_data[SYM_W-1:0];
				REG_REVERSE_COPY:  reverse_copy_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero counts act as one, oversized counts saturate at the limit
	always_comb begin
		if (batch_count_q == '0)
			nb = NBW'(1);
		else if (32'(batch_count_q) > MAX_BATCH)
			nb = NBW'(MAX_BATCH);
		else
			nb = NBW'(batch_count_q);

		if (height_q == '0)
			nh = NSW'(1);
		else if (32'(height_q) > MAX_SIDE)
			nh = NSW'(MAX_SIDE);
		else
			nh = NSW'(height_q);

		if (width_q == '0)
			nw = NSW'(1);
		else if (32'(width_q) > MAX_SIDE)
			nw = NSW'(MAX_SIDE);
		else
			nw = NSW'(width_q);

		if (channel_count_q == '0)
			nc = NCW'(1);
		else if (32'(channel_count_q) > MAX_CHANNELS)
			nc = NCW'(MAX_CHANNELS);
		else
			nc = NCW'(channel_count_q);
	end

	assign layout_nhwc   = layout_nhwc_q;
	assign symmetry_code = symmetry_code_q;
	assign reverse_copy  = reverse_copy_q;

endmodule

### design/tsag_ctrl.sv
// Sequencer: load, three multiply-add passes, output hand-off.
module tsag_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  tsag_pkg::tsag_status_t  status,
	output tsag_pkg::tsag_cmd_t     cmd
);
	import tsag_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_PUSH
	} state_t;

	state_t    state_q;
	mac_step_t step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_OUTER;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MAC;
						step_q  <= STEP_OUTER;
					end
				end
				ST_MAC: begin
					case (step_q)
						STEP_OUTER: step_q <= STEP_MID;
						STEP_MID:   step_q <= STEP_INNER;
						default: begin
							step_q  <= STEP_OUTER;
							state_q <= ST_PUSH;
						end
					endcase
				end
				ST_PUSH: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = s_tready && s_tvalid;
		cmd.mac_en = (state_q == ST_MAC);
		cmd.step   = step_q;
		cmd.push   = (state_q == ST_PUSH) && status.out_free;
	end

endmodule

### design/tsag_dpath.sv
// Walk counters, symmetry mapping, index multiply-add units and output register.
module tsag_dpath #(
	parameter int MAX_SIDE         = 32,
	parameter int MAX_BATCH        = 256,
	parameter int MAX_CHANNELS     = 64,
	parameter int SWAP_PLANE_COUNT = 22,
	localparam int NBW = $clog2(MAX_BATCH + 1),
	localparam int NSW = $clog2(MAX_SIDE + 1),
	localparam int NCW = $clog2(MAX_CHANNELS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsag_pkg::tsag_cmd_t              cmd,
	output tsag_pkg::tsag_status_t           status,
	input  logic                             restart,
	input  logic [NBW-1:0]                   nb,
	input  logic [NSW-1:0]                   nh,
	input  logic [NSW-1:0]                   nw,
	input  logic [NCW-1:0]                   nc,
	input  logic                             layout_nhwc,
	input  logic [tsag_pkg::SYM_W-1:0]       symmetry_code,
	input  logic                             reverse_copy,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [2*tsag_pkg::IDX_W-1:0]     m_tdata,
	output logic                             m_tlast,
	output logic [0:0]                       m_tuser
);
	import tsag_pkg::*;

	localparam int BW  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int SW  = $clog2(MAX_SIDE);
	localparam int CHW = $clog2(MAX_CHANNELS);
	localparam int KW  = (NSW > NCW) ? NSW : NCW;

	// walk position
	logic [BW-1:0]  batch_pos_q;
	logic [SW-1:0]  row_pos_q;
	logic [SW-1:0]  col_pos_q;
	logic [CHW-1:0] chan_pos_q;

	// latched element coordinates
	logic [SW-1:0]  y_q, x_q, sy_q, sx_q;
	logic [CHW-1:0] c_q, sc_q;
	logic           last_q, err_q;

	logic [IDX_W-1:0] raw_acc_q, sym_acc_q;

	logic             m_tvalid_q;
	logic [2*IDX_W-1:0] m_tdata_q;
	logic             m_tlast_q;
	logic             m_tuser_q;

	// position fit
	logic [NBW-1:0] bp_ext;
	logic [NSW-1:0] rp_ext, cp_ext;
	logic [NCW-1:0] chp_ext;
	logic [BW-1:0]  n;
	logic [SW-1:0]  y, x;
	logic [CHW-1:0] c;

	always_comb begin
		bp_ext  = restart ? '0 : NBW'(batch_pos_q);
		rp_ext  = restart ? '0 : NSW'(row_pos_q);
		cp_ext  = restart ? '0 : NSW'(col_pos_q);
		chp_ext = restart ? '0 : NCW'(chan_pos_q);
		n = (bp_ext  >= nb) ? BW'(nb - NBW'(1))  : BW'(bp_ext);
		y = (rp_ext  >= nh) ? SW'(nh - NSW'(1))  : SW'(rp_ext);
		x = (cp_ext  >= nw) ? SW'(nw - NSW'(1))  : SW'(cp_ext);
		c = (chp_ext >= nc) ? CHW'(nc - NCW'(1)) : CHW'(chp_ext);
	end

	// next position, channel innermost
	logic [NCW-1:0] c_inc;
	logic [NSW-1:0] x_inc, y_inc;
	logic [NBW-1:0] n_inc;
	logic           wrap_c, wrap_x, wrap_y, wrap_n;
	logic [BW-1:0]  n_nx;
	logic [SW-1:0]  y_nx, x_nx;
	logic [CHW-1:0] c_nx;

	always_comb begin
		c_inc  = NCW'(c) + NCW'(1);
		x_inc  = NSW'(x) + NSW'(1);
		y_inc  = NSW'(y) + NSW'(1);
		n_inc  = NBW'(n) + NBW'(1);
		wrap_c = (c_inc >= nc);
		wrap_x = (x_inc >= nw);
		wrap_y = (y_inc >= nh);
		wrap_n = (n_inc >= nb);
		c_nx = wrap_c ? '0 : CHW'(c_inc);
		x_nx = x;
		y_nx = y;
		n_nx = n;
		if (wrap_c) begin
			x_nx = wrap_x ? '0 : SW'(x_inc);
			if (wrap_x) begin
				y_nx = wrap_y ? '0 : SW'(y_inc);
				if (wrap_y)
					n_nx = wrap_n ? '0 : BW'(n_inc);
			end
		end
	end

	// symmetry mapping: transpose, then column flip, then row flip
	logic           tr, fx, fy, err, swap, last;
	logic [SW-1:0]  tx, ty, sx, sy;
	logic [CHW-1:0] sc;

	always_comb begin
		tr   = (symmetry_code & SYM_TRANSPOSE) != '0;
		fx   = (symmetry_code & SYM_FLIP_X) != '0;
		fy   = (symmetry_code & SYM_FLIP_Y) != '0;
		err  = tr && (nh != nw);
		tx   = tr ? y : x;
		ty   = tr ? x : y;
		sx   = fx ? SW'(nw - NSW'(1) - NSW'(tx)) : tx;
		sy   = fy ? SW'(nh - NSW'(1) - NSW'(ty)) : ty;
		swap = (32'(nc) == SWAP_PLANE_COUNT) && (fx != fy);
		sc   = c;
		if (swap && c == CHW'(CHAN_SWAP_A))
			sc = CHW'(CHAN_SWAP_B);
		else if (swap && c == CHW'(CHAN_SWAP_B))
			sc = CHW'(CHAN_SWAP_A);
		last = (NBW'(n) == nb - NBW'(1)) && (NSW'(y) == nh - NSW'(1)) &&
			(NSW'(x) == nw - NSW'(1)) && (NCW'(c) == nc - NCW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_pos_q <= '0;
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			chan_pos_q  <= '0;
		end else if (cmd.load) begin
			batch_pos_q <= n_nx;
			row_pos_q   <= y_nx;
			col_pos_q   <= x_nx;
			chan_pos_q  <= c_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q    <= y;
			x_q    <= x;
			c_q    <= c;
			sy_q   <= err ? y : sy;
			sx_q   <= err ? x : sx;
			sc_q   <= err ? c : sc;
			last_q <= last;
			err_q  <= err;
		end
	end

	// multiply-add operands per pass and layout
	logic [KW-1:0]    k;
	logic [IDX_W-1:0] raw_add, sym_add;

	always_comb begin
		case (cmd.step)
			STEP_OUTER: begin
				k       = layout_nhwc ? KW'(nh) : KW'(nc);
				raw_add = layout_nhwc ? IDX_W'(y_q)  : IDX_W'(c_q);
				sym_add = layout_nhwc ? IDX_W'(sy_q) : IDX_W'(sc_q);
			end
			STEP_MID: begin
				k       = layout_nhwc ? KW'(nw) : KW'(nh);
				raw_add = layout_nhwc ? IDX_W'(x_q)  : IDX_W'(y_q);
				sym_add = layout_nhwc ? IDX_W'(sx_q) : IDX_W'(sy_q);
			end
			STEP_INNER: begin
				k       = layout_nhwc ? KW'(nc) : KW'(nw);
				raw_add = layout_nhwc ? IDX_W'(c_q)  : IDX_W'(x_q);
				sym_add = layout_nhwc ? IDX_W'(sc_q) : IDX_W'(sx_q);
			end
			default: begin
				k       = '0;
				raw_add = '0;
				sym_add = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_acc_q <= IDX_W'(n);
			sym_acc_q <= IDX_W'(n);
		end else if (cmd.mac_en) begin
			raw_acc_q <= raw_acc_q * IDX_W'(k) + raw_add;
			sym_acc_q <= sym_acc_q * IDX_W'(k) + sym_add;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.push)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			m_tdata_q <= reverse_copy ? {raw_acc_q, sym_acc_q} : {sym_acc_q, raw_acc_q};
			m_tlast_q <= last_q;
			m_tuser_q <= err_q;
		end
	end

	assign status.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

### design/tensor_symmetry_address_generator_unit.sv
// A request runs through load, three multiply-add passes of the raw and symmetric index units
//   (outer, middle, inner dimension) and the hand-off, which waits while the output register is
//   full and not drained; m_tvalid rises after the hand-off, and no new request is taken before it.
// The next request is taken while an earlier result still sits in the output register.
// Reset (arst_n low, asynchronous): walk returns to element zero, counts go to one, layout,
//   symmetry and direction to zero, and no result is pending.
module tensor_symmetry_address_generator_unit #(
	parameter int MAX_SIDE         = 32,
	parameter int MAX_BATCH        = 256,
	parameter int MAX_CHANNELS     = 64,
	parameter int SWAP_PLANE_COUNT = 22
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request side
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [0] restart, [7:1] zero
	// result side
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [2*tsag_pkg::IDX_W-1:0]        m_tdata,   // [23:0] source_index, [47:24] dest_index
	output logic                                m_tlast,   // last_element
	output logic [0:0]                          m_tuser,   // [0] size_error
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tsag_pkg::*;

`include "tensor_symmetry_address_generator_unit_defines.svh"

	localparam int NBW = $clog2(MAX_BATCH + 1);
	localparam int NSW = $clog2(MAX_SIDE + 1);
	localparam int NCW = $clog2(MAX_CHANNELS + 1);

	// effective (clamped) sizes: user keeps stable while a request is in flight, not enforced
	logic [NBW-1:0]   nb;
	logic [NSW-1:0]   nh, nw;
	logic [NCW-1:0]   nc;
	logic             layout_nhwc;
	logic [SYM_W-1:0] symmetry_code;
	logic             reverse_copy;

	tsag_cmd_t    cmd;
	tsag_status_t status;

	tsag_cfg_regs #(
		.MAX_SIDE     (MAX_SIDE),
		.MAX_BATCH    (MAX_BATCH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.nb            (nb),
		.nh            (nh),
		.nw            (nw),
		.nc            (nc),
		.layout_nhwc   (layout_nhwc),
		.symmetry_code (symmetry_code),
		.reverse_copy  (reverse_copy)
	);

	// sequencer: owns s_tready and steps the datapath
	tsag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// walk counters, symmetry map, raw and symmetric index units, output register
	tsag_dpath #(
		.MAX_SIDE         (MAX_SIDE),
		.MAX_BATCH        (MAX_BATCH),
		.MAX_CHANNELS     (MAX_CHANNELS),
		.SWAP_PLANE_COUNT (SWAP_PLANE_COUNT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.restart       (s_tdata[0]),
		.nb            (nb),
		.nh            (nh),
		.nw            (nw),
		.nc            (nc),
		.layout_nhwc   (layout_nhwc),
		.symmetry_code (symmetry_code),
		.reverse_copy  (reverse_copy),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser)
	);

	// one request in flight at a time
	`TSAG_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while busy")
	// a result only appears out of the hand-off state
	`TSAG_ASSERT_SAME(a_result_from_work, clk, arst_n, $rose(m_tvalid), !$past(s_tready), "result without work")
	// size error means no symmetry: both indices are the raw one
	`TSAG_ASSERT_SAME(a_error_raw_pair, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[23:0] == m_tdata[47:24], "size error with differing indices")

endmodule

### tb/tsag_addr_checker.sv
// Scoreboard for the tensor symmetry address generator: predicts every address pair and compares.
`timescale 1ns / 100ps
module tsag_addr_checker #(
	parameter int MAX_SIDE         = 32,
	parameter int MAX_BATCH        = 256,
	parameter int MAX_CHANNELS     = 64,
	parameter int SWAP_PLANE_COUNT = 22
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // [0] restart, [7:1] zero
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [2*tsag_pkg::IDX_W-1:0]    m_tdata,    // [23:0] source_index, [47:24] dest_index
	input  logic                            m_tlast,    // last_element
	input  logic [0:0]                      m_tuser,    // [0] size_error
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tsag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsag_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                     pending,
	output int unsigned                     fail_count,
	output int unsigned                     pairs_checked,
	output int unsigned                     last_count,
	output int unsigned                     error_count
);
	import tsag_pkg::*;

	localparam int BATCH_POS_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int SIDE_POS_W  = $clog2(MAX_SIDE);
	localparam int CHAN_POS_W  = $clog2(MAX_CHANNELS);

	typedef struct packed {
		logic [IDX_W-1:0] src_index;
		logic [IDX_W-1:0] dst_index;
		logic             last_elem;
		logic             size_err;
	} addr_pair_t;

	// shadow registers
	logic [BATCH_REG_W-1:0] batch_reg;
	logic [SIDE_REG_W-1:0]  height_reg;
	logic [SIDE_REG_W-1:0]  width_reg;
	logic [CHAN_REG_W-1:0]  chan_reg;
	logic                   nhwc_reg;
	logic [SYM_W-1:0]       sym_reg;
	logic                   reverse_reg;

	// walk position
	logic [BATCH_POS_W-1:0] batch_pos;
	logic [SIDE_POS_W-1:0]  row_pos;
	logic [SIDE_POS_W-1:0]  col_pos;
	logic [CHAN_POS_W-1:0]  chan_pos;

	addr_pair_t pair_q[$];

	function automatic int unsigned fit_count(input int unsigned v, input int unsigned limit);
		if (v == 0) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	function automatic int unsigned fit_pos(input int unsigned p, input int unsigned count);
		return (p >= count) ? count - 1 : p;
	endfunction

	function automatic logic [IDX_W-1:0] flat_index(input logic nhwc, input int unsigned n,
			input int unsigned y, input int unsigned x, input int unsigned c,
			input int unsigned nh, input int unsigned nw, input int unsigned nc);
		int unsigned v;
		if (nhwc)
			v = ((n * nh + y) * nw + x) * nc + c;
		else
			v = ((n * nc + c) * nh + y) * nw + x;
		return v[IDX_W-1:0];
	endfunction

	task automatic predict_pair(input logic restart, output addr_pair_t pair);
		int unsigned nb, nh, nw, nc, n, y, x, c, sx, sy, sc;
		logic transpose, flip_x, flip_y, size_err;
		logic [IDX_W-1:0] raw, mirrored;
		nb = fit_count(batch_reg, MAX_BATCH);
		nh = fit_count(height_reg, MAX_SIDE);
		nw = fit_count(width_reg, MAX_SIDE);
		nc = fit_count(chan_reg, MAX_CHANNELS);
		transpose = (sym_reg & SYM_TRANSPOSE) != '0;
		flip_x    = (sym_reg & SYM_FLIP_X) != '0;
		flip_y    = (sym_reg & SYM_FLIP_Y) != '0;
		size_err  = transpose && (nh != nw);
		if (restart) begin
			batch_pos = '0;
			row_pos   = '0;
			col_pos   = '0;
			chan_pos  = '0;
		end
		// registers may have shrunk under a walk in progress
		n = fit_pos(batch_pos, nb);
		y = fit_pos(row_pos, nh);
		x = fit_pos(col_pos, nw);
		c = fit_pos(chan_pos, nc);
		raw = flat_index(nhwc_reg, n, y, x, c, nh, nw, nc);
		if (size_err) begin
			mirrored = raw;
		end else begin
			sx = transpose ? y : x;
			sy = transpose ? x : y;
			if (flip_x) sx = nw - 1 - sx;
			if (flip_y) sy = nh - 1 - sy;
			sc = c;
			if (nc == SWAP_PLANE_COUNT && flip_x != flip_y) begin
				if (c == CHAN_SWAP_A) sc = CHAN_SWAP_B;
				else if (c == CHAN_SWAP_B) sc = CHAN_SWAP_A;
			end
			mirrored = flat_index(nhwc_reg, n, sy, sx, sc, nh, nw, nc);
		end
		pair.src_index = reverse_reg ? mirrored : raw;
		pair.dst_index = reverse_reg ? raw : mirrored;
		pair.last_elem = (n == nb - 1) && (y == nh - 1) && (x == nw - 1) && (c == nc - 1);
		pair.size_err  = size_err;
		// step channel, column, row, batch; wrap after the final element
		c++;
		if (c >= nc) begin
			c = 0;
			x++;
			if (x >= nw) begin
				x = 0;
				y++;
				if (y >= nh) begin
					y = 0;
					n++;
					if (n >= nb) n = 0;
				end
			end
		end
		batch_pos = n[BATCH_POS_W-1:0];
		row_pos   = y[SIDE_POS_W-1:0];
		col_pos   = x[SIDE_POS_W-1:0];
		chan_pos  = c[CHAN_POS_W-1:0];
	endtask

	task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
			input logic [IDX_W-1:0] want);
		$display("[%0t] mismatch on %s: got 0x%06h, expected 0x%06h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		addr_pair_t want;
		addr_pair_t next_pair;
		if (!arst_n) begin
			batch_reg     = BATCH_REG_W'(1);
			height_reg    = SIDE_REG_W'(1);
			width_reg     = SIDE_REG_W'(1);
			chan_reg      = CHAN_REG_W'(1);
			nhwc_reg      = 1'b0;
			sym_reg       = '0;
			reverse_reg   = 1'b0;
			batch_pos     = '0;
			row_pos       = '0;
			col_pos       = '0;
			chan_pos      = '0;
			fail_count    = 0;
			pairs_checked = 0;
			last_count    = 0;
			error_count   = 0;
			pair_q.delete();
			pending <= 0;
		end else begin
			// results first: a request taken at this edge cannot already have its result out
			if (m_tvalid && m_tready) begin
				pairs_checked++;
				if (pair_q.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata[IDX_W-1:0], '0);
				end else begin
					want = pair_q.pop_front();
					if (m_tdata[IDX_W-1:0] !== want.src_index)
						report_mismatch("source_index", m_tdata[IDX_W-1:0], want.src_index);
					if (m_tdata[2*IDX_W-1:IDX_W] !== want.dst_index)
						report_mismatch("dest_index", m_tdata[2*IDX_W-1:IDX_W], want.dst_index);
					if (m_tlast !== want.last_elem)
						report_mismatch("last_element", IDX_W'(m_tlast), IDX_W'(want.last_elem));
					if (m_tuser[0] !== want.size_err)
						report_mismatch("size_error", IDX_W'(m_tuser[0]), IDX_W'(want.size_err));
				end
			end
			// a request taken at this edge still sees the registers as they were before it
			if (s_tvalid && s_tready) begin
				predict_pair(s_tdata[0], next_pair);
				if (next_pair.last_elem) last_count++;
				if (next_pair.size_err) error_count++;
				pair_q.insert(pair_q.size(), next_pair);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_BATCH_COUNT:   batch_reg   = cfg_data[BATCH_REG_W-1:0];
					REG_HEIGHT:        height_reg  = cfg_data[SIDE_REG_W-1:0];
					REG_WIDTH:         width_reg   = cfg_data[SIDE_REG_W-1:0];
					REG_CHANNEL_COUNT: chan_reg    = cfg_data[CHAN_REG_W-1:0];
					REG_LAYOUT_NHWC:   nhwc_reg    = cfg_data[0];
					REG_SYMMETRY_CODE: sym_reg     = cfg_data[SYM_W-1:0];
					REG_REVERSE_COPY:  reverse_reg = cfg_data[0];
					default: ;
				endcase
			end
			pending <= pair_q.size();
		end
	end

endmodule

### tb/tb_tensor_symmetry_address_generator_unit.sv
// Testbench top for the tensor symmetry address generator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_tensor_symmetry_address_generator_unit;
	import tsag_pkg::*;

	localparam int MAX_SIDE         = 32;
	localparam int MAX_BATCH        = 256;
	localparam int MAX_CHANNELS     = 64;
	localparam int SWAP_PLANE_COUNT = 22;

	localparam int RANDOM_ITEMS = 430;
	// settling margin for the multiply-add passes, the output register and a stalled receiver
	localparam int DRAIN_CYCLES = 12;
	// long receiver hold-off, far longer than the block can buffer
	localparam int HOLD_CYCLES  = 120;
	// watchdog limit, with plenty of margin over the slowest correct run
	localparam int RUN_LIMIT    = 200000;

	localparam logic [SYM_W-1:0] SYM_NONE = '0;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;     // [0] restart, [7:1] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [2*IDX_W-1:0]    m_tdata;          // [23:0] source_index, [47:24] dest_index
	logic                  m_tlast;          // last_element
	logic [0:0]            m_tuser;          // [0] size_error
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned pairs_checked;
	int unsigned last_count;
	int unsigned error_count;

	// flow control knobs, percent of cycles
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	// set by the stimulus for one phase; the receiver then holds off once
	logic        pressure_on = 1'b0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	int unsigned cycle_count = 0;
	int unsigned requests_sent = 0;
	int unsigned directed_requests = 0;
	int unsigned random_requests = 0;
	int unsigned cfg_writes = 0;
	int unsigned phase_count = 0;

	tensor_symmetry_address_generator_unit #(
		.MAX_SIDE         (MAX_SIDE),
		.MAX_BATCH        (MAX_BATCH),
		.MAX_CHANNELS     (MAX_CHANNELS),
		.SWAP_PLANE_COUNT (SWAP_PLANE_COUNT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tsag_addr_checker #(
		.MAX_SIDE         (MAX_SIDE),
		.MAX_BATCH        (MAX_BATCH),
		.MAX_CHANNELS     (MAX_CHANNELS),
		.SWAP_PLANE_COUNT (SWAP_PLANE_COUNT)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.fail_count    (fail_count),
		.pairs_checked (pairs_checked),
		.last_count    (last_count),
		.error_count   (error_count)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls per the current knob, plus one long hold-off when
	// the pressure phase asks for it. The hold counts its own cycles here so the
	// sender keeps offering requests and the block has to back up into s_tready.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (pressure_on && !hold_done) begin
			hold_left = HOLD_CYCLES - 1;
			hold_done = 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Idling modes, cycled per phase: none, sender gaps, receiver stalls, both.
	task automatic set_idle(input int unsigned mode);
		case (mode % 4)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
			default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
		endcase
	endtask

	// One register write; cfg_valid stays up so back-to-back writes need no gap.
	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_writes++;
	endtask

	// Registers only change with the block idle: the sender pauses until every
	// expected pair is back, then lets the pipeline settle before writing.
	task automatic load_settings(input int unsigned nb, input int unsigned nh,
			input int unsigned nw, input int unsigned nc, input logic nhwc,
			input logic [SYM_W-1:0] code, input logic rev);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_BATCH_COUNT, nb);
		write_reg(REG_HEIGHT, nh);
		write_reg(REG_WIDTH, nw);
		write_reg(REG_CHANNEL_COUNT, nc);
		write_reg(REG_LAYOUT_NHWC, nhwc);
		write_reg(REG_SYMMETRY_CODE, code);
		write_reg(REG_REVERSE_COPY, rev);
		cfg_valid <= 1'b0;
	endtask

	// One request, after a random gap; s_tvalid is left high for a following request.
	task automatic send_request(input logic restart);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, restart};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
	endtask

	// A run of requests: the first with the given restart, the rest restarting
	// at the given percentage, mostly advancing the walk.
	task automatic run_requests(input int unsigned count, input logic first_restart,
			input int unsigned restart_pct);
		for (int unsigned i = 0; i < count; i++)
			send_request((i == 0) ? first_restart : ($urandom_range(99) < restart_pct));
		s_tvalid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned nb, nh, nw, nc, count, r;
		logic [SYM_W-1:0] code;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		set_idle(0);
		// reset values: 1x1x1x1, every element is the last; advance then restart
		run_requests(2, 1'b0, 100);
		// zero counts act as one; all symmetry bits, channel-innermost, reverse direction
		load_settings(0, 0, 0, 0, 1'b1, SYM_TRANSPOSE | SYM_FLIP_X | SYM_FLIP_Y, 1'b1);
		run_requests(2, 1'b1, 0);
		// oversized counts clamp to the limits; transpose plus row flip on a 32x32 plane
		load_settings(511, 63, 63, 127, 1'b0, SYM_TRANSPOSE | SYM_FLIP_Y, 1'b0);
		run_requests(3, 1'b1, 0);
		// swap-plane channel count with a single column flip: channels 6 and 7 trade
		load_settings(1, 2, 2, SWAP_PLANE_COUNT, 1'b1, SYM_FLIP_X, 1'b0);
		run_requests(9, 1'b1, 0);
		// transpose on a 2x3 plane: size error, raw indices both ways
		set_idle(3);
		load_settings(2, 2, 3, 1, 1'b0, SYM_TRANSPOSE, 1'b1);
		run_requests(4, 1'b1, 0);
		// shrink under the walk in progress, no restart: positions clamp to the new sizes
		load_settings(1, 1, 1, 1, 1'b1, SYM_FLIP_X | SYM_FLIP_Y, 1'b0);
		run_requests(2, 1'b0, 0);
		directed_requests = requests_sent;

		// ---- random part: small tensors mostly so walks wrap and hit the last element ----
		while (random_requests < RANDOM_ITEMS) begin
			phase_count++;
			set_idle(phase_count);

			r = $urandom_range(99);
			if (r < 5)       nb = 0;
			else if (r < 8)  nb = MAX_BATCH;
			else if (r < 10) nb = 511;
			else             nb = $urandom_range(1, 3);

			r = $urandom_range(99);
			if (r < 5)       nh = 0;
			else if (r < 9)  nh = MAX_SIDE;
			else if (r < 12) nh = 63;
			else             nh = $urandom_range(1, 4);

			r = $urandom_range(99);
			if (r < 5)       nw = 0;
			else if (r < 9)  nw = MAX_SIDE;
			else if (r < 12) nw = 63;
			else             nw = $urandom_range(1, 4);

			r = $urandom_range(99);
			if (r < 5)       nc = 0;
			else if (r < 15) nc = SWAP_PLANE_COUNT;
			else if (r < 18) nc = MAX_CHANNELS;
			else if (r < 20) nc = 127;
			else             nc = $urandom_range(1, 8);

			code = SYM_W'($urandom_range(7));
			// most transposes on a square plane so the symmetry path gets exercised
			if ((code & SYM_TRANSPOSE) != SYM_NONE && $urandom_range(99) < 70)
				nw = nh;

			load_settings(nb, nh, nw, nc, 1'($urandom_range(1)), code,
				1'($urandom_range(1)));

			count = $urandom_range(12, 36);
			if (phase_count == 3) begin
				// pressure phase: steady sender against a long receiver hold-off
				set_idle(0);
				count = 40;
				pressure_on = 1'b1;
			end
			run_requests(count, 1'($urandom_range(1)), 4);
			pressure_on = 1'b0;
			random_requests += count;
		end

		// ---- drain and verdict ----
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests (%0d directed), %0d random phases, %0d reg writes",
			requests_sent, directed_requests, phase_count, cfg_writes);
		$display("checked %0d address pairs: %0d final elements, %0d size errors, %0d mismatches",
			pairs_checked, last_count, error_count, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
